// ===== design/lifegrid_pkg.sv =====
// Shared types and constants for the cell grid generation engine.
// Used by life_grid_generation_step; has no dependencies.
`default_nettype none

package lifegrid_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_HALO = 2'd2;

  localparam logic [6:0] DIM_RESET = 7'd64;

  typedef logic [12:0] changed_t;
  typedef logic [47:0] total_t;
  typedef logic [31:0] gen_t;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_READ   = 2'd1,
    OP_EVOLVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RMW,
    S_FETCH,
    S_CELL,
    S_STORE,
    S_COPY
  } state_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [6:0] row;
    logic [6:0] column;
    logic       cell_value;
  } in_word_t;

  typedef struct packed {
    logic     read_value;
    changed_t changed_cells;
    total_t   total_changed;
    gen_t     generation;
    logic     out_of_range;
  } out_word_t;

endpackage

`default_nettype wire

// ===== design/life_grid_generation_step.sv =====
// Cell grid engine with B3/S23 generation step, row-word grid memory and
// next-generation row buffer. Depends on lifegrid_pkg.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_stall   | in_word  (lifegrid_pkg::in_word_t)
//   out     | output    | out_valid / out_stall | out_word (lifegrid_pkg::out_word_t)
//   cfg     | input     | cfg_write             | cfg_index, cfg_data
//
// A write or read passes through the read-modify-write state; an out-of-range
// access is answered from idle. An evolve works row by row for h rows and w
// columns: three row fetches through the single grid read port, one cell per
// cycle across the row, and a row store; a copy pass from the row buffer ends it.
// After reset a clearing pass zeroes every grid row, halo rows included; no
// word is accepted during it. One word is in work at a time; a result
// held by out_stall blocks the next word.
`default_nettype none

module life_grid_generation_step #(
  parameter int MAX_ROWS = lifegrid_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = lifegrid_pkg::MAX_COLS_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  lifegrid_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire                     out_stall,
  output lifegrid_pkg::out_word_t out_word,
  input  wire                     cfg_write,
  input  wire [1:0]               cfg_index,
  input  wire [6:0]               cfg_data
);

  localparam int DEPTH = MAX_ROWS + 2;
  localparam int W2    = MAX_COLS + 2;
  localparam int RW    = $clog2(DEPTH);
  localparam int CW    = $clog2(W2);
  localparam int KW    = $clog2(MAX_ROWS);
  localparam int CHW   = $clog2(MAX_ROWS * MAX_COLS + 1);

  logic [W2-1:0] grid_mem [DEPTH];
  logic [W2-1:0] next_mem [MAX_ROWS];

  lifegrid_pkg::state_t state, state_next;

  logic [6:0] grid_rows, grid_cols;
  logic       halo_mode;

  logic [1:0]    op_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic          val_q;
  logic [RW-1:0] y, cnt;
  logic [CW-1:0] x;
  logic [KW-1:0] k;
  logic [1:0]    fcnt;
  logic [W2-1:0] up, cur, dn, newrow;
  logic [CHW-1:0] chg;
  lifegrid_pkg::gen_t   gen_count;
  lifegrid_pkg::total_t change_total;

  logic          grid_we, next_we, out_load, accept, nv;
  logic [RW-1:0] grid_raddr, grid_waddr;
  logic [W2-1:0] grid_wdata, grid_rdata, next_rdata;
  logic [KW-1:0] next_raddr;
  lifegrid_pkg::out_word_t out_next;

  logic [RW-1:0] h_dim, o_r, ylast, yu, yd;
  logic [CW-1:0] w_dim, o_c, xlast, xl, xr;
  logic [RW:0]   srows;
  logic [CW:0]   scols;
  logic [3:0]    ncount;
  logic          in_oor;

  always_comb begin
    if (grid_rows == 7'd0) begin
      h_dim = RW'(1);
    end else if (32'(grid_rows) > MAX_ROWS) begin
      h_dim = RW'(MAX_ROWS);
    end else begin
      h_dim = RW'(grid_rows);
    end
    if (grid_cols == 7'd0) begin
      w_dim = CW'(1);
    end else if (32'(grid_cols) > MAX_COLS) begin
      w_dim = CW'(MAX_COLS);
    end else begin
      w_dim = CW'(grid_cols);
    end
    o_r   = {{(RW-1){1'b0}}, halo_mode};
    o_c   = {{(CW-1){1'b0}}, halo_mode};
    srows = {1'b0, h_dim} + {{(RW-1){1'b0}}, halo_mode, 1'b0};
    scols = {1'b0, w_dim} + {{(CW-1){1'b0}}, halo_mode, 1'b0};
    in_oor = (32'(in_word.row) >= 32'(srows)) || (32'(in_word.column) >= 32'(scols));
    ylast = h_dim + o_r - RW'(1);
    xlast = w_dim + o_c - CW'(1);
    if (halo_mode) begin
      yu = y - RW'(1);
      yd = y + RW'(1);
      xl = x - CW'(1);
      xr = x + CW'(1);
    end else begin
      yu = (y == RW'(0)) ? h_dim - RW'(1) : y - RW'(1);
      yd = (y == ylast) ? RW'(0) : y + RW'(1);
      xl = (x == CW'(0)) ? w_dim - CW'(1) : x - CW'(1);
      xr = (x == xlast) ? CW'(0) : x + CW'(1);
    end
    ncount = 4'(up[xl]) + 4'(up[x]) + 4'(up[xr]) + 4'(cur[xl]) + 4'(cur[xr])
           + 4'(dn[xl]) + 4'(dn[x]) + 4'(dn[xr]);
    nv = (ncount == 4'd3) || ((ncount == 4'd2) && cur[x]);
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    grid_raddr = RW'(in_word.row);
    grid_we    = 1'b0;
    grid_waddr = row_q;
    grid_wdata = grid_rdata;
    next_we    = 1'b0;
    next_raddr = cnt[KW-1:0];
    out_load   = 1'b0;
    out_next.read_value    = 1'b0;
    out_next.changed_cells = '0;
    out_next.total_changed = change_total;
    out_next.generation    = gen_count;
    out_next.out_of_range  = 1'b0;
    case (state)
      lifegrid_pkg::S_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = cnt;
        grid_wdata = '0;
        if (cnt == RW'(DEPTH - 1)) begin
          state_next = lifegrid_pkg::S_IDLE;
        end
      end
      lifegrid_pkg::S_IDLE: begin
        in_stall = out_valid && out_stall;
        accept   = in_valid && !in_stall;
        if (accept) begin
          case (in_word.operation)
            lifegrid_pkg::OP_WRITE, lifegrid_pkg::OP_READ: begin
              if (in_oor) begin
                out_load = 1'b1;
                out_next.out_of_range = 1'b1;
              end else begin
                state_next = lifegrid_pkg::S_RMW;
              end
            end
            lifegrid_pkg::OP_EVOLVE: begin
              state_next = lifegrid_pkg::S_FETCH;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      lifegrid_pkg::S_RMW: begin
        out_load = 1'b1;
        if (op_q == lifegrid_pkg::OP_WRITE) begin
          grid_we = 1'b1;
          grid_wdata[col_q] = val_q;
        end else begin
          out_next.read_value = grid_rdata[col_q];
        end
        state_next = lifegrid_pkg::S_IDLE;
      end
      lifegrid_pkg::S_FETCH: begin
        case (fcnt)
          2'd0:    grid_raddr = yu;
          2'd1:    grid_raddr = y;
          default: grid_raddr = yd;
        endcase
        if (fcnt == 2'd3) begin
          state_next = lifegrid_pkg::S_CELL;
        end
      end
      lifegrid_pkg::S_CELL: begin
        if (x == xlast) begin
          state_next = lifegrid_pkg::S_STORE;
        end
      end
      lifegrid_pkg::S_STORE: begin
        next_we = 1'b1;
        state_next = (y == ylast) ? lifegrid_pkg::S_COPY : lifegrid_pkg::S_FETCH;
      end
      lifegrid_pkg::S_COPY: begin
        if (cnt != RW'(0)) begin
          grid_we    = 1'b1;
          grid_waddr = cnt - RW'(1) + o_r;
          grid_wdata = next_rdata;
        end
        if (cnt == h_dim) begin
          out_load = 1'b1;
          out_next.changed_cells = lifegrid_pkg::changed_t'(chg);
          out_next.total_changed = change_total + lifegrid_pkg::total_t'(chg);
          out_next.generation    = gen_count + 32'd1;
          state_next = lifegrid_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = lifegrid_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (grid_we) begin
      grid_mem[grid_waddr] <= grid_wdata;
    end
    grid_rdata <= grid_mem[grid_raddr];
    if (next_we) begin
      next_mem[k] <= newrow;
    end
    next_rdata <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lifegrid_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= '0;
      out_valid    <= 1'b0;
      gen_count    <= '0;
      change_total <= '0;
      grid_rows    <= lifegrid_pkg::DIM_RESET;
      grid_cols    <= lifegrid_pkg::DIM_RESET;
      halo_mode    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lifegrid_pkg::CFG_ROWS: grid_rows <= cfg_data;
          lifegrid_pkg::CFG_COLS: grid_cols <= cfg_data;
          lifegrid_pkg::CFG_HALO: halo_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid    <= 1'b1;
        out_word     <= out_next;
        gen_count    <= out_next.generation;
        change_total <= out_next.total_changed;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        lifegrid_pkg::S_CLEAR: begin
          cnt <= cnt + RW'(1);
        end
        lifegrid_pkg::S_IDLE: begin
          if (accept) begin
            op_q  <= in_word.operation;
            row_q <= RW'(in_word.row);
            col_q <= CW'(in_word.column);
            val_q <= in_word.cell_value;
            y     <= o_r;
            k     <= '0;
            fcnt  <= 2'd0;
            chg   <= '0;
          end
        end
        lifegrid_pkg::S_FETCH: begin
          fcnt <= fcnt + 2'd1;
          case (fcnt)
            2'd1: up <= grid_rdata;
            2'd2: begin
              cur    <= grid_rdata;
              newrow <= grid_rdata;
            end
            2'd3: begin
              dn <= grid_rdata;
              x  <= o_c;
            end
            default: ;
          endcase
        end
        lifegrid_pkg::S_CELL: begin
          newrow[x] <= nv;
          if (nv != cur[x]) begin
            chg <= chg + CHW'(1);
          end
          x <= x + CW'(1);
        end
        lifegrid_pkg::S_STORE: begin
          k    <= k + KW'(1);
          y    <= y + RW'(1);
          fcnt <= 2'd0;
          cnt  <= '0;
        end
        lifegrid_pkg::S_COPY: begin
          cnt <= cnt + RW'(1);
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state != lifegrid_pkg::S_IDLE) |-> in_stall)
    else $error("word accepted while busy");

  assert property (@(posedge clk) disable iff (rst)
    grid_we |-> (state == lifegrid_pkg::S_CLEAR || state == lifegrid_pkg::S_RMW ||
                 state == lifegrid_pkg::S_COPY))
    else $error("grid written during generation pass");

  assert property (@(posedge clk) disable iff (rst)
    (state == lifegrid_pkg::S_CELL) |-> (x <= xlast))
    else $error("column walk ran past the row");

  assert property (@(posedge clk) disable iff (rst)
    (state != lifegrid_pkg::S_COPY) |=> (gen_count == $past(gen_count)))
    else $error("generation count moved outside the copy pass");

endmodule

`default_nettype wire

// ===== bench/life_grid_generation_step_tb.sv =====
// Self-checking bench for life_grid_generation_step: drives cell writes, reads and
// generation steps, predicts every result word with a B3/S23 grid model and compares.
// Depends on lifegrid_pkg and the life_grid_generation_step RTL.
`default_nettype none

module life_grid_generation_step_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class life_scoreboard;
    bit cells[66][66];
    int unsigned rows_cfg;
    int unsigned cols_cfg;
    bit halo;
    lifegrid_pkg::gen_t gen_count;
    lifegrid_pkg::total_t change_sum;
    lifegrid_pkg::out_word_t pending[$];
    int mismatches;

    function void clear_state();
      foreach (cells[r, c]) cells[r][c] = 1'b0;
      rows_cfg = 64;
      cols_cfg = 64;
      halo = 1'b0;
      gen_count = '0;
      change_sum = '0;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [6:0] value);
      if (idx == lifegrid_pkg::CFG_ROWS) rows_cfg = 32'(value);
      else if (idx == lifegrid_pkg::CFG_COLS) cols_cfg = 32'(value);
      else if (idx == lifegrid_pkg::CFG_HALO) halo = value[0];
    endfunction

    function int unsigned clamp_size(int unsigned v);
      if (v < 1) return 1;
      if (v > 64) return 64;
      return v;
    endfunction

    function lifegrid_pkg::changed_t step_generation();
      int unsigned h, w, o, n, r, c, changes, k;
      bit nxt[4096];
      h = clamp_size(rows_cfg);
      w = clamp_size(cols_cfg);
      o = halo;
      changes = 0;
      k = 0;
      for (int y = o; y < h + o; y++) begin
        for (int x = o; x < w + o; x++) begin
          n = 0;
          for (int i = 0; i < 3; i++) begin
            r = o ? (y - 1 + i) : ((y + h - 1 + i) % h);
            for (int j = 0; j < 3; j++) begin
              c = o ? (x - 1 + j) : ((x + w - 1 + j) % w);
              n += cells[r][c];
            end
          end
          n -= cells[y][x];
          nxt[k] = (n == 3) || (n == 2 && cells[y][x]);
          if (nxt[k] != cells[y][x]) changes++;
          k++;
        end
      end
      k = 0;
      for (int y = o; y < h + o; y++) begin
        for (int x = o; x < w + o; x++) begin
          cells[y][x] = nxt[k];
          k++;
        end
      end
      gen_count = gen_count + 1;
      change_sum = change_sum + changes;
      return lifegrid_pkg::changed_t'(changes);
    endfunction

    function void note_input(lifegrid_pkg::in_word_t w);
      lifegrid_pkg::out_word_t e;
      int unsigned sr, sc;
      e = '0;
      if (w.operation == lifegrid_pkg::OP_WRITE || w.operation == lifegrid_pkg::OP_READ) begin
        sr = clamp_size(rows_cfg) + (halo ? 2 : 0);
        sc = clamp_size(cols_cfg) + (halo ? 2 : 0);
        if (w.row >= sr || w.column >= sc) e.out_of_range = 1'b1;
        else if (w.operation == lifegrid_pkg::OP_WRITE) cells[w.row][w.column] = w.cell_value;
        else e.read_value = cells[w.row][w.column];
      end else if (w.operation == lifegrid_pkg::OP_EVOLVE) begin
        e.changed_cells = step_generation();
      end
      e.total_changed = change_sum;
      e.generation = gen_count;
      pending.push_back(e);
    endfunction

    function void check_result(lifegrid_pkg::out_word_t got);
      lifegrid_pkg::out_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.read_value !== e.read_value || got.changed_cells !== e.changed_cells ||
          got.total_changed !== e.total_changed || got.generation !== e.generation ||
          got.out_of_range !== e.out_of_range) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp rd=%0d chg=%0d tot=%0d gen=%0d oor=%0d",
                    " got rd=%0d chg=%0d tot=%0d gen=%0d oor=%0d"},
                   e.read_value, e.changed_cells, e.total_changed, e.generation,
                   e.out_of_range, got.read_value, got.changed_cells, got.total_changed,
                   got.generation, got.out_of_range);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  lifegrid_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  lifegrid_pkg::out_word_t out_word;
  logic cfg_write = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  life_scoreboard grid_model = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int hold_count = 0;
  bit hold_done = 1'b0;

  life_grid_generation_step dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) grid_model.check_result(out_word);
  end

  always @(negedge clk) begin
    if (hold_len > 0 && !hold_done) begin
      out_stall <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count == hold_len - 1) hold_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_word(logic [1:0] op, logic [6:0] r, logic [6:0] c, logic v);
    lifegrid_pkg::in_word_t w;
    w.operation = op;
    w.row = r;
    w.column = c;
    w.cell_value = v;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    grid_model.note_input(w);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grid_model.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_register(logic [1:0] idx, logic [6:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    grid_model.set_register(idx, value);
  endtask

  task automatic set_grid(logic [6:0] r, logic [6:0] c, logic h);
    drain();
    write_register(lifegrid_pkg::CFG_ROWS, r);
    write_register(lifegrid_pkg::CFG_COLS, c);
    write_register(lifegrid_pkg::CFG_HALO, {6'd0, h});
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(int count);
    int unsigned pick, sr, sc;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      sr = grid_model.clamp_size(grid_model.rows_cfg) + (grid_model.halo ? 2 : 0);
      sc = grid_model.clamp_size(grid_model.cols_cfg) + (grid_model.halo ? 2 : 0);
      if (pick < 50)
        send_word(lifegrid_pkg::OP_WRITE, 7'($urandom_range(sr - 1)),
                  7'($urandom_range(sc - 1)), 1'($urandom_range(1)));
      else if (pick < 70)
        send_word(lifegrid_pkg::OP_READ, 7'($urandom_range(sr - 1)),
                  7'($urandom_range(sc - 1)), 1'($urandom_range(1)));
      else if (pick < 85)
        send_word(lifegrid_pkg::OP_EVOLVE, 7'($urandom_range(127)),
                  7'($urandom_range(127)), 1'($urandom_range(1)));
      else
        send_word(2'($urandom_range(3)), 7'($urandom_range(127)),
                  7'($urandom_range(127)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    grid_model.clear_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_word(lifegrid_pkg::OP_READ, 7'd0, 7'd0, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd0, 7'd1, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd1, 7'd1, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd2, 7'd1, 1'b1);
    send_word(lifegrid_pkg::OP_EVOLVE, 7'd0, 7'd0, 1'b0);
    send_word(lifegrid_pkg::OP_READ, 7'd1, 7'd0, 1'b0);
    send_word(lifegrid_pkg::OP_EVOLVE, 7'd127, 7'd127, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd63, 7'd63, 1'b1);
    send_word(lifegrid_pkg::OP_READ, 7'd63, 7'd63, 1'b0);
    send_word(lifegrid_pkg::OP_WRITE, 7'd64, 7'd0, 1'b1);
    send_word(lifegrid_pkg::OP_READ, 7'd0, 7'd127, 1'b0);
    send_word(lifegrid_pkg::OP_NONE, 7'd127, 7'd127, 1'b1);
    set_grid(7'd1, 7'd2, 1'b0);
    send_word(lifegrid_pkg::OP_WRITE, 7'd0, 7'd0, 1'b1);
    send_word(lifegrid_pkg::OP_EVOLVE, 7'd0, 7'd0, 1'b0);
    send_word(lifegrid_pkg::OP_READ, 7'd0, 7'd1, 1'b0);
    set_grid(7'd0, 7'd127, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd0, 7'd0, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd1, 7'd65, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd2, 7'd1, 1'b1);
    send_word(lifegrid_pkg::OP_EVOLVE, 7'd0, 7'd0, 1'b0);
    send_word(lifegrid_pkg::OP_READ, 7'd2, 7'd1, 1'b0);
    set_grid(7'd3, 7'd3, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd0, 7'd1, 1'b1);
    send_word(lifegrid_pkg::OP_WRITE, 7'd4, 7'd4, 1'b1);
    send_word(lifegrid_pkg::OP_EVOLVE, 7'd0, 7'd0, 1'b0);

    send_idle_pct = 17;
    recv_idle_pct = 75;
    set_grid(7'd6, 7'd5, 1'b0);
    random_phase(25);
    set_grid(7'd4, 7'd8, 1'b1);
    random_phase(10);
    hold_len = 200;
    random_phase(6);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 17;
    set_grid(7'd2, 7'd2, 1'b0);
    random_phase(20);
    set_grid(7'd7, 7'd3, 1'b1);
    random_phase(20);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(7'd64, 7'd64, 1'b0);
    random_phase(10);
    set_grid(7'd64, 7'd64, 1'b1);
    random_phase(10);
    set_grid(7'd5, 7'd6, 1'b0);
    random_phase(20);
    drain();

    if (grid_model.mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire

// ===== sim.f =====
design/lifegrid_pkg.sv
design/life_grid_generation_step.sv
bench/life_grid_generation_step_tb.sv
